[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the checker file mra_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Property checked on every rising edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

[design/mra_pkg.sv]
// ----------------------------------------------------------------------------
// mra_pkg
// Types and constants of the mouse report accumulator.
// ----------------------------------------------------------------------------
package mra_pkg;

  localparam int DEVICES = 2;
  localparam int BUTTONS = 3;
  localparam int DEV_SEL_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

  localparam int LATCH_W = 11;
  localparam int FLAG_BASE = 8;
  localparam logic [LATCH_W-1:0] BUTTON_MASK = LATCH_W'(8'hFF);

  typedef enum logic [2:0] {
    OP_REPORT       = 3'd0,
    OP_READ_CLEAR   = 3'd1,
    OP_SET_POS      = 3'd2,
    OP_RESET        = 3'd3,
    OP_CLEAR_TIMERS = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    CFG_READ_MODE       = 3'd0,
    CFG_ACCEL_THRESHOLD = 3'd1,
    CFG_ACCEL_GAIN      = 3'd2,
    CFG_X_LOW_BOUND     = 3'd3,
    CFG_X_HIGH_BOUND    = 3'd4,
    CFG_Y_LOW_BOUND     = 3'd5,
    CFG_Y_HIGH_BOUND    = 3'd6,
    CFG_DOUBLE_CLICK_MS = 3'd7
  } cfg_reg_t;

  localparam logic        MODE_RELATIVE = 1'b0;
  localparam logic        MODE_ABSOLUTE = 1'b1;

  localparam logic [16:0] RST_ACCEL_THRESHOLD = 17'd65536;
  localparam logic [23:0] RST_ACCEL_GAIN      = 24'd65536;
  localparam logic signed [31:0] RST_LOW_BOUND  = -32'sd1000000;
  localparam logic signed [31:0] RST_HIGH_BOUND = 32'sd1000000;
  localparam logic [31:0] RST_DOUBLE_CLICK_MS = 32'd500;

endpackage

[design/mra_delta_scale.sv]
// ----------------------------------------------------------------------------
// mra_delta_scale
// Applies the 8.16 gain to a report delta whose magnitude reaches the
// threshold; the product is shifted right arithmetically by 16.
// ----------------------------------------------------------------------------
module mra_delta_scale (
  input  logic signed [7:0]  delta,
  input  logic        [16:0] threshold,
  input  logic        [23:0] gain,
  output logic signed [31:0] scaled
);

  logic        [8:0]  mag;
  logic signed [32:0] prod;
  logic signed [32:0] shifted;

  always_comb begin
    mag = delta[7] ? 9'(-$signed({delta[7], delta})) : {1'b0, delta};
    prod = $signed({{25{delta[7]}}, delta}) * $signed({9'b0, gain});
    shifted = prod >>> 16;
    if ({8'b0, mag} >= threshold) begin
      scaled = shifted[31:0];
    end else begin
      scaled = 32'(delta);
    end
  end

endmodule

[design/mouse_report_accumulator_core.sv]
// ----------------------------------------------------------------------------
// mouse_report_accumulator_core
// Accumulates mouse reports into x, y and wheel totals with gain on large
// deltas, clamping in absolute mode and per-device double-click detection.
// One request is taken every cycle unless in_stall is high. A request lands
// in an input register, is applied to the state as it leaves that register,
// and its result is held in a result register written with the state. The
// rate is set by the state update: each request reads the state that the
// one before it left. The configuration port is always ready; the user must
// write it only while the block is idle, and the block does not enforce it.
// ----------------------------------------------------------------------------
module mouse_report_accumulator_core (
  input  logic               clk,
  input  logic               rst,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [2:0]  op,
  input  logic        [0:0]  device_index,
  input  logic        [7:0]  button_bits,
  input  logic signed [7:0]  delta_x,
  input  logic signed [7:0]  delta_y,
  input  logic signed [7:0]  delta_wheel,
  input  logic        [31:0] now_ms,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] wheel_total,
  output logic        [10:0] button_state
);

  localparam int NB = mra_pkg::BUTTONS;
  localparam int ND = mra_pkg::DEVICES;
  localparam int LW = mra_pkg::LATCH_W;

  // configuration
  logic               read_mode;
  logic        [16:0] accel_threshold;
  logic        [23:0] accel_gain;
  logic signed [31:0] x_low_bound;
  logic signed [31:0] x_high_bound;
  logic signed [31:0] y_low_bound;
  logic signed [31:0] y_high_bound;
  logic        [31:0] double_click_ms;

  // input register
  logic               s1_valid;
  mra_pkg::op_t       s1_op;
  logic        [0:0]  s1_dev;
  logic        [7:0]  s1_btn;
  logic signed [7:0]  s1_dx;
  logic signed [7:0]  s1_dy;
  logic signed [7:0]  s1_dw;
  logic        [31:0] s1_now;
  logic signed [31:0] s1_tx;
  logic signed [31:0] s1_ty;

  // state
  logic signed [31:0] cursor_x;
  logic signed [31:0] cursor_y;
  logic signed [31:0] wheel_sum;
  logic      [LW-1:0] button_latch;
  logic      [NB-1:0] press_pending [ND];
  logic        [31:0] press_time    [ND][NB];

  // step logic
  logic                             s1_adv;
  logic                             s1_fire;
  logic                             dev_ok;
  logic [mra_pkg::DEV_SEL_W-1:0]    dev_sel;
  logic signed [31:0]               scaled_x;
  logic signed [31:0] scaled_y;
  logic signed [31:0] x_next;
  logic signed [31:0] y_next;
  logic signed [31:0] wheel_next;
  logic      [LW-1:0] latch_next;
  logic signed [31:0] x_kept;
  logic signed [31:0] y_kept;
  logic signed [31:0] wheel_kept;
  logic      [LW-1:0] latch_kept;
  logic      [NB-1:0] pend_row_next;
  logic      [NB-1:0] time_store;
  logic        [15:0] flags;
  logic               pend_write;

  function automatic logic signed [31:0] clamp_seq(input logic signed [31:0] v,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
    logic signed [31:0] s;
    s = v;
    if (s < lo) s = lo;
    if (s > hi) s = hi;
    return s;
  endfunction

  function automatic logic signed [31:0] clamp_set(input logic signed [31:0] v,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
    logic signed [31:0] s;
    if (v < lo) s = lo;
    else if (v > hi) s = hi;
    else s = v;
    return s;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_mode       <= mra_pkg::MODE_RELATIVE;
      accel_threshold <= mra_pkg::RST_ACCEL_THRESHOLD;
      accel_gain      <= mra_pkg::RST_ACCEL_GAIN;
      x_low_bound     <= mra_pkg::RST_LOW_BOUND;
      x_high_bound    <= mra_pkg::RST_HIGH_BOUND;
      y_low_bound     <= mra_pkg::RST_LOW_BOUND;
      y_high_bound    <= mra_pkg::RST_HIGH_BOUND;
      double_click_ms <= mra_pkg::RST_DOUBLE_CLICK_MS;
    end else if (cfg_valid && cfg_ready) begin
      case (mra_pkg::cfg_reg_t'(cfg_index))
        mra_pkg::CFG_READ_MODE:       read_mode       <= cfg_data[0];
        mra_pkg::CFG_ACCEL_THRESHOLD: accel_threshold <= cfg_data[16:0];
        mra_pkg::CFG_ACCEL_GAIN:      accel_gain      <= cfg_data[23:0];
        mra_pkg::CFG_X_LOW_BOUND:     x_low_bound     <= cfg_data;
        mra_pkg::CFG_X_HIGH_BOUND:    x_high_bound    <= cfg_data;
        mra_pkg::CFG_Y_LOW_BOUND:     y_low_bound     <= cfg_data;
        mra_pkg::CFG_Y_HIGH_BOUND:    y_high_bound    <= cfg_data;
        mra_pkg::CFG_DOUBLE_CLICK_MS: double_click_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // flow control
  assign s1_adv   = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op  <= mra_pkg::op_t'(op);
      s1_dev <= device_index;
      s1_btn <= button_bits;
      s1_dx  <= delta_x;
      s1_dy  <= delta_y;
      s1_dw  <= delta_wheel;
      s1_now <= now_ms;
      s1_tx  <= target_x;
      s1_ty  <= target_y;
    end
  end

  mra_delta_scale u_scale_x (
    .delta     (s1_dx),
    .threshold (accel_threshold),
    .gain      (accel_gain),
    .scaled    (scaled_x)
  );

  mra_delta_scale u_scale_y (
    .delta     (s1_dy),
    .threshold (accel_threshold),
    .gain      (accel_gain),
    .scaled    (scaled_y)
  );

  assign dev_ok  = 32'(s1_dev) < 32'(ND);
  assign dev_sel = mra_pkg::DEV_SEL_W'(s1_dev);

  always_comb begin
    x_next        = cursor_x;
    y_next        = cursor_y;
    wheel_next    = wheel_sum;
    latch_next    = button_latch;
    pend_row_next = press_pending[dev_sel];
    time_store    = '0;
    flags         = '0;
    pend_write    = 1'b0;
    case (s1_op)
      mra_pkg::OP_REPORT: begin
        x_next     = cursor_x + scaled_x;
        y_next     = cursor_y + scaled_y;
        wheel_next = wheel_sum + 32'(s1_dw);
        if (dev_ok) begin
          pend_write = 1'b1;
          for (int b = 0; b < NB; b++) begin
            if (!button_latch[b] && s1_btn[b]) begin
              if (press_pending[dev_sel][b] &&
                  (s1_now - press_time[dev_sel][b]) < double_click_ms) begin
                flags[mra_pkg::FLAG_BASE + b] = 1'b1;
                pend_row_next[b] = 1'b0;
              end else begin
                pend_row_next[b] = 1'b1;
                time_store[b]    = 1'b1;
              end
            end
          end
        end
        latch_next = LW'({8'h00, s1_btn} | flags);
        if (read_mode == mra_pkg::MODE_ABSOLUTE) begin
          x_next = clamp_seq(x_next, x_low_bound, x_high_bound);
          y_next = clamp_seq(y_next, y_low_bound, y_high_bound);
        end
      end
      mra_pkg::OP_SET_POS: begin
        x_next = clamp_set(s1_tx, x_low_bound, x_high_bound);
        y_next = clamp_set(s1_ty, y_low_bound, y_high_bound);
      end
      mra_pkg::OP_RESET: begin
        wheel_next = '0;
        latch_next = '0;
        if (read_mode == mra_pkg::MODE_ABSOLUTE) begin
          x_next = x_low_bound;
          y_next = y_low_bound;
        end else begin
          x_next = '0;
          y_next = '0;
        end
      end
      mra_pkg::OP_CLEAR_TIMERS: begin
        if (dev_ok) begin
          pend_write    = 1'b1;
          pend_row_next = '0;
        end
      end
      default: ;
    endcase

    // read and clear acts after the result is taken
    x_kept     = x_next;
    y_kept     = y_next;
    wheel_kept = wheel_next;
    latch_kept = latch_next;
    if (s1_op == mra_pkg::OP_READ_CLEAR) begin
      if (read_mode == mra_pkg::MODE_RELATIVE) begin
        x_kept = '0;
        y_kept = '0;
      end
      wheel_kept = '0;
      latch_kept = latch_next & mra_pkg::BUTTON_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= '0;
      cursor_y     <= '0;
      wheel_sum    <= '0;
      button_latch <= '0;
      for (int d = 0; d < ND; d++) begin
        press_pending[d] <= '0;
      end
    end else if (s1_fire) begin
      cursor_x     <= x_kept;
      cursor_y     <= y_kept;
      wheel_sum    <= wheel_kept;
      button_latch <= latch_kept;
      if (pend_write) begin
        press_pending[dev_sel] <= pend_row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      for (int b = 0; b < NB; b++) begin
        if (time_store[b]) begin
          press_time[dev_sel][b] <= s1_now;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      pos_x        <= x_next;
      pos_y        <= y_next;
      wheel_total  <= wheel_next;
      button_state <= latch_next;
    end
  end

endmodule

[design/mra_checker.sv]
// ----------------------------------------------------------------------------
// mra_checker
// Port-level checks of the mouse report accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mra_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] pos_x,
  input logic signed [31:0] pos_y,
  input logic signed [31:0] wheel_total,
  input logic        [10:0] button_state
);

  logic [106:0] result_bits;

  assign result_bits = {pos_x, pos_y, wheel_total, button_state};

  // a stalled result stays
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid)

  `ASSERT_CLK(a_out_stable, clk, rst, out_valid && out_stall |=> $stable(result_bits))

  // input side only backs up when the result register is full and held
  `ASSERT_CLK(a_stall_cause, clk, rst, in_stall |-> out_valid && out_stall)

  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && !in_stall)

endmodule

bind mouse_report_accumulator_core mra_checker u_mra_checker (.*);
